// ===== hdl/wmh_pkg.sv =====
package wmh_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_LIMIT  = 3'd1,
        CMD_ACCUM  = 3'd2,
        CMD_STATS  = 3'd3,
        CMD_BIN    = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_SEARCH,
        ST_MULT,
        ST_WRITE,
        ST_OUT
    } state_t;

    localparam int unsigned DEFAULT_CLASSES = 5;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  variable_index;
        logic [4:0]  slot_index;
        logic [31:0] value;
        logic [15:0] weight;
        logic        is_missing;
        logic        new_record;
    } item_t;

    typedef struct packed {
        logic        in_range;
        logic [3:0]  class_found;
        logic [31:0] sample_count;
        logic [47:0] weight_total;
        logic [63:0] weighted_sum;
        logic [62:0] weighted_square_sum;
        logic [31:0] record_count;
        logic [31:0] bin_count;
        logic        saturated;
    } result_t;

    typedef struct packed {
        logic [31:0] cnt;
        logic [47:0] wsum;
        logic [63:0] sum;
        logic [62:0] sq;
        logic        sat;
    } acc_t;

endpackage

// ===== hdl/wmh_stream_if.sv =====
interface wmh_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/weighted_moments_histogram_core.sv =====
// Channel  | Dir | Payload   | Transfer
// in_ch    | in  | item_t    | valid & ready at clk rise
// out_ch   | out | result_t  | valid & ready at clk rise
// cfg      | in  | 5 bits    | cfg_we at clk rise
// One transaction at a time. Stats, bin, limit and unknown commands pass through
// read and output before their result shows. Accumulate passes through read, a
// limit search trying one class per step (1 up to the clamped class_count, at
// most 2 for a rejected sample), multiply, write back, output. After reset and
// after a clear command, a sweep over NUM_VARS*MAX_CLASSES addresses zeroes the
// memories; no input is taken during it.
// A pending result holds in the output register until it is taken; the next
// transaction can be taken in the cycle after that.
module weighted_moments_histogram_core
    import wmh_pkg::*;
#(
    parameter int unsigned NUM_VARS    = 16,
    parameter int unsigned MAX_CLASSES = 16
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_wdata,
    wmh_stream_if.sink    in_ch,
    wmh_stream_if.source  out_ch
);
    localparam int unsigned VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int unsigned CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int unsigned BD = NUM_VARS * MAX_CLASSES;
    localparam int unsigned BW = (BD > 1) ? $clog2(BD) : 1;
    localparam int unsigned LW = $clog2(MAX_CLASSES + 1);
    localparam int unsigned AW = $bits(acc_t);

    state_t state_reg, state_next;
    logic [4:0]  class_count_reg;
    item_t       item_reg;
    logic [31:0] limit_reg [MAX_CLASSES + 1];
    logic [31:0] records_reg;
    logic [BW:0] sweep_reg;
    logic [LW:0] k_reg;
    logic [LW:0] cc_reg;
    logic        hit_reg;
    logic        found_reg;
    logic [47:0] prod_reg;
    logic [63:0] x2_reg;
    logic [63:0] sq_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        out_valid_reg;

    // memories
    logic          acc_we, bin_we;
    logic [VW-1:0] acc_addr;
    acc_t          acc_wdata, acc_rdata;
    logic [BW-1:0] bin_addr;
    logic [31:0]   bin_wdata, bin_rdata;
    logic [AW-1:0] acc_rraw;

    wmh_acc_mem #(.DEPTH(NUM_VARS), .WIDTH(AW)) u_acc (
        .clk(clk), .we(acc_we), .waddr(acc_addr), .wdata(acc_wdata),
        .raddr(acc_addr), .rdata(acc_rraw)
    );
    assign acc_rdata = acc_t'(acc_rraw);

    wmh_acc_mem #(.DEPTH(BD), .WIDTH(32)) u_bin (
        .clk(clk), .we(bin_we), .waddr(bin_addr), .wdata(bin_wdata),
        .raddr(bin_addr), .rdata(bin_rdata)
    );

    logic var_ok;
    assign var_ok = ({28'd0, item_reg.variable_index} < 32'(NUM_VARS));
    logic [LW:0] k_sel;
    assign k_sel = found_reg ? k_reg : (cc_reg - 1'b1);

    always_comb
    begin
        acc_addr = item_reg.variable_index[VW-1:0];
        bin_addr = BW'(item_reg.variable_index[VW-1:0] * MAX_CLASSES
                       + item_reg.slot_index[CW-1:0]);
        if (state_reg == ST_CLEAR)
        begin
            acc_addr = sweep_reg[VW-1:0];
            bin_addr = sweep_reg[BW-1:0];
        end
        else if (state_reg == ST_WRITE || state_reg == ST_MULT)
        begin
            bin_addr = BW'(item_reg.variable_index[VW-1:0] * MAX_CLASSES
                           + k_sel[CW-1:0]);
        end
    end

    // saturating updates
    logic [48:0] w_add;
    logic [64:0] s_add;
    logic [63:0] q_add;
    logic        c_full, b_full, w_sat, s_sat, q_sat;
    always_comb
    begin
        c_full = &acc_rdata.cnt;
        b_full = &bin_rdata;
        w_add  = {1'b0, acc_rdata.wsum} + {33'd0, item_reg.weight};
        w_sat  = w_add[48];
        s_add  = {acc_rdata.sum[63], acc_rdata.sum}
                 + {{17{prod_reg[47]}}, prod_reg};
        s_sat  = (s_add[64] != s_add[63]);
        q_add  = {1'b0, acc_rdata.sq} + sq_reg;
        q_sat  = q_add[63] || sq_reg[63];
        acc_wdata = '0;
        if (state_reg == ST_WRITE)
        begin
            acc_wdata.cnt  = c_full ? acc_rdata.cnt : acc_rdata.cnt + 32'd1;
            acc_wdata.wsum = w_sat ? '1 : w_add[47:0];
            acc_wdata.sum  = s_sat ? (s_add[64] ? 64'h8000_0000_0000_0000
                                                : 64'h7FFF_FFFF_FFFF_FFFF)
                                   : s_add[63:0];
            acc_wdata.sq   = q_sat ? '1 : q_add[62:0];
            acc_wdata.sat  = acc_rdata.sat | c_full | b_full | w_sat | s_sat | q_sat;
        end
        bin_wdata = (state_reg == ST_WRITE)
                    ? (b_full ? bin_rdata : bin_rdata + 32'd1) : 32'd0;
        acc_we = (state_reg == ST_CLEAR && sweep_reg < (BW+1)'(NUM_VARS))
                 || (state_reg == ST_WRITE && hit_reg);
        bin_we = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE && hit_reg);
    end

    // state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && !out_valid_reg)
                begin
                    state_next = ST_READ;
                end
            end
            ST_CLEAR:
            begin
                if (sweep_reg == (BW+1)'(BD - 1))
                begin
                    state_next = (item_reg.command == CMD_CLEAR) ? ST_OUT : ST_IDLE;
                end
            end
            ST_READ:
            begin
                unique case (item_reg.command)
                    CMD_CLEAR: state_next = ST_CLEAR;
                    CMD_ACCUM: state_next = ST_SEARCH;
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_SEARCH:
            begin
                if (!hit_reg || found_reg || k_reg + 1'b1 >= cc_reg)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:   state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign in_ch.ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;

    logic signed [31:0] xv;
    logic [31:0]        xa;
    assign xv = signed'(item_reg.value);
    assign xa = xv[31] ? 32'(-xv) : xv;

    // assemble the result; record_count is always set, other fields a command does not name stay zero
    always_comb
    begin
        res_next = '0;
        res_next.record_count = records_reg;
        if (item_reg.command == CMD_ACCUM && hit_reg)
        begin
            res_next.in_range    = 1'b1;
            res_next.class_found = 4'(k_sel);
        end
        if (item_reg.command == CMD_STATS && var_ok)
        begin
            res_next.sample_count        = acc_rdata.cnt;
            res_next.weight_total        = acc_rdata.wsum;
            res_next.weighted_sum        = acc_rdata.sum;
            res_next.weighted_square_sum = acc_rdata.sq;
            res_next.saturated           = acc_rdata.sat;
        end
        if (item_reg.command == CMD_BIN && var_ok)
        begin
            res_next.saturated = acc_rdata.sat;
            if (32'(item_reg.slot_index) < 32'(MAX_CLASSES))
                res_next.bin_count = bin_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            class_count_reg <= 5'(DEFAULT_CLASSES);
            records_reg     <= '0;
            sweep_reg       <= '0;
            out_valid_reg   <= 1'b0;
            // not a clear command, so the reset sweep drops back to idle silently
            item_reg        <= '{command: CMD_STATS, default: '0};
            for (int i = 0; i <= MAX_CLASSES; i++)
            begin
                limit_reg[i] <= 32'(i) << 16;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                class_count_reg <= cfg_wdata;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                item_reg  <= in_ch.data;
                sweep_reg <= '0;
            end
            if (state_reg == ST_CLEAR)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (state_reg == ST_READ)
            begin
                // hold class count for the search; clamp to 1..MAX_CLASSES
                if (class_count_reg == 5'd0)
                    cc_reg <= (LW+1)'(1);
                else if (32'(class_count_reg) > 32'(MAX_CLASSES))
                    cc_reg <= (LW+1)'(MAX_CLASSES);
                else
                    cc_reg <= (LW+1)'(class_count_reg);
                k_reg     <= '0;
                found_reg <= 1'b0;
                if (item_reg.command == CMD_CLEAR)
                begin
                    records_reg <= '0;
                end
                if (item_reg.command == CMD_LIMIT
                    && 32'(item_reg.slot_index) <= 32'(MAX_CLASSES))
                begin
                    limit_reg[item_reg.slot_index[LW-1:0]] <= item_reg.value;
                end
                if (item_reg.command == CMD_ACCUM && item_reg.new_record
                    && !(&records_reg))
                begin
                    records_reg <= records_reg + 32'd1;
                end
            end
            if (state_reg == ST_SEARCH)
            begin
                if (k_reg == '0 && !found_reg)
                begin
                    hit_reg <= !item_reg.is_missing && var_ok
                        && (signed'(item_reg.value) > signed'(limit_reg[0]))
                        && (signed'(item_reg.value)
                            <= signed'(limit_reg[cc_reg[LW-1:0]]));
                end
                if (!found_reg && k_reg + 1'b1 < cc_reg)
                begin
                    if (signed'(item_reg.value)
                        <= signed'(limit_reg[LW'(k_reg + 1'b1)]))
                        found_reg <= 1'b1;
                    else
                        k_reg <= k_reg + 1'b1;
                end
                prod_reg <= 48'($signed({{16{xv[31]}}, xv})
                                * $signed({32'd0, item_reg.weight}));
                x2_reg   <= 64'(xa) * 64'(xa);
            end
            if (state_reg == ST_MULT)
            begin
                sq_reg <= 64'(item_reg.weight) * 64'(x2_reg[63:24])
                          + ((64'(item_reg.weight) * 64'(x2_reg[23:0])) >> 24);
            end
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end
            if (state_reg == ST_READ && item_reg.command == CMD_ACCUM)
            begin
                hit_reg <= 1'b1;
            end
        end
    end
endmodule

// ===== hdl/wmh_acc_mem.sv =====
module wmh_acc_mem
    import wmh_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/wmh_checker.sv =====
module wmh_checker
    import wmh_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input open with result pending");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.in_range |-> out_data.class_found == 4'd0)
        else $error("class without hit");
endmodule

bind weighted_moments_histogram_core wmh_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
